// ===== src/ppmd_pkg.sv =====
package ppmd_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int CNT_W        = 4;
  localparam int PW_W         = 16;
  localparam int VAL_W        = 16;
  localparam int CODE_W       = 8;
  localparam int ALPHA_W      = 64;
  localparam int CFG_ADDR_W   = 3;
  localparam int STEP_W       = 3;
  localparam int DIV_STEPS    = 16;
  localparam int PROD_W       = 27;
  localparam int SUM_W        = 19;

  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_NCH   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA = 3'd4;

  localparam logic [PW_W-1:0]    SYNC_RST  = 16'd3000;
  localparam logic [PW_W-1:0]    MIN_RST   = 16'd1000;
  localparam logic [PW_W-1:0]    MAX_RST   = 16'd2000;
  localparam logic [CNT_W-1:0]   NCH_RST   = 4'd8;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = '1;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_WAIT   = 3'd1,
    OP_DECIDE = 3'd2,
    OP_DIV    = 3'd3,
    OP_MUL    = 3'd4,
    OP_UPD    = 3'd5,
    OP_FIN    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    JC_NONE     = 3'd0,
    JC_ALWAYS   = 3'd1,
    JC_NO_INPUT = 3'd2,
    JC_SKIP_UPD = 3'd3,
    JC_DIV_BUSY = 3'd4,
    JC_OUT_BUSY = 3'd5
  } jc_t;

  typedef struct packed {
    op_t               op;
    jc_t               cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic skip_upd;
    logic div_busy;
    logic out_busy;
  } stat_t;

  localparam logic [STEP_W-1:0] ST_WAIT   = 3'd0;
  localparam logic [STEP_W-1:0] ST_DECIDE = 3'd1;
  localparam logic [STEP_W-1:0] ST_DIV    = 3'd2;
  localparam logic [STEP_W-1:0] ST_MUL    = 3'd3;
  localparam logic [STEP_W-1:0] ST_UPD    = 3'd4;
  localparam logic [STEP_W-1:0] ST_FIN    = 3'd5;
  localparam logic [STEP_W-1:0] ST_RET    = 3'd6;

  // microprogram
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      ST_WAIT:   w = '{op: OP_WAIT,   cond: JC_NO_INPUT, target: ST_WAIT};
      ST_DECIDE: w = '{op: OP_DECIDE, cond: JC_SKIP_UPD, target: ST_FIN};
      ST_DIV:    w = '{op: OP_DIV,    cond: JC_DIV_BUSY, target: ST_DIV};
      ST_MUL:    w = '{op: OP_MUL,    cond: JC_NONE,     target: ST_WAIT};
      ST_UPD:    w = '{op: OP_UPD,    cond: JC_NONE,     target: ST_WAIT};
      ST_FIN:    w = '{op: OP_FIN,    cond: JC_OUT_BUSY, target: ST_FIN};
      default:   w = '{op: OP_NOP,    cond: JC_ALWAYS,   target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== src/ppmd_seq.sv =====
module ppmd_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  ppmd_pkg::stat_t   stat,
  output ppmd_pkg::ctrl_t   ctrl
);

  logic [ppmd_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        take;

  assign ctrl = ppmd_pkg::rom_word(step_r);

  always_comb begin
    unique case (ctrl.cond)
      ppmd_pkg::JC_NONE:     take = 1'b0;
      ppmd_pkg::JC_ALWAYS:   take = 1'b1;
      ppmd_pkg::JC_NO_INPUT: take = stat.no_input;
      ppmd_pkg::JC_SKIP_UPD: take = stat.skip_upd;
      ppmd_pkg::JC_DIV_BUSY: take = stat.div_busy;
      ppmd_pkg::JC_OUT_BUSY: take = stat.out_busy;
      default:               take = 1'b1;
    endcase
    step_nxt = take ? ctrl.target : step_r + ppmd_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ppmd_pkg::ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== src/ppm_frame_decoder_with_smoothing.sv =====
// channel | ports                          | payload
// in      | in_tvalid/in_tready/in_tdata   | pulse width, us
// out     | out_tvalid/out_tready/out_*    | channel, value, flags, frame end
// cfg     | cfg_wr_en/cfg_addr/cfg_wdata   | five registers, write only
//
// an in-range pulse inside a frame passes through the one-bit-per-cycle
// restoring divider, a multiply and an update before its result step;
// other pulses skip those steps; the result register lets the next pulse in
// while a result waits, and only a full result register stalls the program
// synchronous active-low reset puts the program at its wait step at once
module ppm_frame_decoder_with_smoothing (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pulse_width_us
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] channel, [18:3] value, zero pad
  output logic [1:0]  out_tuser,  // [0] updated, [1] frame_start
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  localparam int PW  = ppmd_pkg::PW_W;
  localparam int VW  = ppmd_pkg::VAL_W;
  localparam int CW  = ppmd_pkg::CH_W;
  localparam int NW  = ppmd_pkg::CNT_W;

  ppmd_pkg::ctrl_t ctrl;
  ppmd_pkg::stat_t stat;

  // configuration
  logic [PW-1:0]                   sync_r, min_r, max_r;
  logic [NW-1:0]                   nch_r;
  logic [ppmd_pkg::ALPHA_W-1:0]    alpha_r;

  // frame state
  logic                            in_frame_r;
  logic [CW-1:0]                   slot_r;
  logic signed [VW-1:0]            chan_r [ppmd_pkg::MAX_CHANNELS];

  // datapath
  logic [PW-1:0]                   x_r, span_r, rem_r, q_r;
  logic [NW-1:0]                   cnt_r;
  logic                            upd_r;
  logic signed [ppmd_pkg::PROD_W-1:0] prod_r;

  // result register
  logic                            out_valid_r;
  logic [CW-1:0]                   out_ch_r;
  logic [VW-1:0]                   out_val_r;
  logic                            out_upd_r, out_fs_r, out_fe_r;

  logic                            in_fire, out_free, in_range;
  logic [PW:0]                     rem2, rem2_sub;
  logic signed [VW-1:0]            y_cur, xn;
  logic signed [VW:0]              diff;
  logic [ppmd_pkg::CODE_W:0]       code1;
  logic signed [ppmd_pkg::SUM_W-1:0] sum;
  logic signed [VW-1:0]            y_new;
  logic [NW-1:0]                   n_act, s_inc;
  logic                            last_slot;

  assign in_tready = (ctrl.op == ppmd_pkg::OP_WAIT);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_range  = (x_r > min_r) && (x_r < max_r);

  assign stat.no_input = !in_fire;
  assign stat.skip_upd = !(in_frame_r && in_range);
  assign stat.div_busy = (cnt_r != NW'(ppmd_pkg::DIV_STEPS - 1));
  assign stat.out_busy = !out_free;

  ppmd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  always_comb begin
    rem2     = {rem_r, 1'b0};
    rem2_sub = rem2 - {1'b0, span_r};
    y_cur    = chan_r[slot_r];
    xn       = $signed(q_r ^ 16'h8000);
    diff     = {xn[VW-1], xn} - {y_cur[VW-1], y_cur};
    code1    = {1'b0, alpha_r[slot_r*ppmd_pkg::CODE_W +: ppmd_pkg::CODE_W]} + 9'd1;
    sum      = {{(ppmd_pkg::SUM_W-VW){y_cur[VW-1]}}, y_cur}
             + prod_r[ppmd_pkg::PROD_W-1:8];
    if (sum > 19'sd32767) begin
      y_new = 16'sh7fff;
    end else if (sum < -19'sd32768) begin
      y_new = -16'sh8000;
    end else begin
      y_new = sum[VW-1:0];
    end
    if (nch_r == '0) begin
      n_act = NW'(1);
    end else if (nch_r > NW'(ppmd_pkg::MAX_CHANNELS)) begin
      n_act = NW'(ppmd_pkg::MAX_CHANNELS);
    end else begin
      n_act = nch_r;
    end
    s_inc     = {1'b0, slot_r} + NW'(1);
    last_slot = (s_inc >= n_act);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r  <= ppmd_pkg::SYNC_RST;
      min_r   <= ppmd_pkg::MIN_RST;
      max_r   <= ppmd_pkg::MAX_RST;
      nch_r   <= ppmd_pkg::NCH_RST;
      alpha_r <= ppmd_pkg::ALPHA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        ppmd_pkg::CFG_SYNC:  sync_r  <= cfg_wdata[PW-1:0];
        ppmd_pkg::CFG_MIN:   min_r   <= cfg_wdata[PW-1:0];
        ppmd_pkg::CFG_MAX:   max_r   <= cfg_wdata[PW-1:0];
        ppmd_pkg::CFG_NCH:   nch_r   <= cfg_wdata[NW-1:0];
        ppmd_pkg::CFG_ALPHA: alpha_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r <= in_tdata;
    end
    case (ctrl.op)
      ppmd_pkg::OP_DECIDE: begin
        rem_r  <= x_r - min_r;
        span_r <= max_r - min_r;
        cnt_r  <= '0;
        upd_r  <= in_frame_r && in_range;
      end
      ppmd_pkg::OP_DIV: begin
        cnt_r <= cnt_r + NW'(1);
        if (!rem2_sub[PW]) begin
          rem_r <= rem2_sub[PW-1:0];
          q_r   <= {q_r[PW-2:0], 1'b1};
        end else begin
          rem_r <= rem2[PW-1:0];
          q_r   <= {q_r[PW-2:0], 1'b0};
        end
      end
      ppmd_pkg::OP_MUL: begin
        prod_r <= ppmd_pkg::PROD_W'(diff) * ppmd_pkg::PROD_W'($signed({1'b0, code1}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ppmd_pkg::MAX_CHANNELS; i++) begin
        chan_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.op == ppmd_pkg::OP_UPD) begin
        chan_r[slot_r] <= y_new;
      end
      if (ctrl.op == ppmd_pkg::OP_FIN && out_free) begin
        out_valid_r <= 1'b1;
        if (!in_frame_r) begin
          out_ch_r  <= '0;
          out_val_r <= '0;
          out_upd_r <= 1'b0;
          out_fs_r  <= (x_r > sync_r);
          out_fe_r  <= 1'b0;
          if (x_r > sync_r) begin
            in_frame_r <= 1'b1;
            slot_r     <= '0;
          end
        end else begin
          out_ch_r  <= slot_r;
          out_val_r <= y_cur;
          out_upd_r <= upd_r;
          out_fs_r  <= 1'b0;
          out_fe_r  <= last_slot;
          if (last_slot) begin
            in_frame_r <= 1'b0;
            slot_r     <= '0;
          end else begin
            slot_r <= s_inc[CW-1:0];
          end
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_val_r, out_ch_r};
  assign out_tuser  = {out_fs_r, out_upd_r};
  assign out_tlast  = out_fe_r;

  a_fs_not_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[0]))
    else $error("frame start and update on one item");

  a_fs_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tlast))
    else $error("frame start and frame end on one item");

  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (slot_r == '0))
    else $error("slot index not cleared outside a frame");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == ppmd_pkg::OP_DIV && stat.div_busy) |=> (cnt_r == $past(cnt_r) + NW'(1)))
    else $error("divider step count did not advance");

  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (ctrl.op == ppmd_pkg::OP_DECIDE))
    else $error("accepted item not followed by decide step");

endmodule
